### design/lobm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;

    localparam int ID_W    = 32;
    localparam int PRICE_W = 16;
    localparam int QTY_W   = 24;
    localparam int DEPTH_W = 29;
    localparam int CNT_W   = 6;
    localparam int KIND_W  = 3;

    // result kinds
    localparam logic [KIND_W-1:0] RK_TRADE     = 3'd0;
    localparam logic [KIND_W-1:0] RK_RESTED    = 3'd1;
    localparam logic [KIND_W-1:0] RK_FILLED    = 3'd2;
    localparam logic [KIND_W-1:0] RK_MKT_DROP  = 3'd3;
    localparam logic [KIND_W-1:0] RK_FULL_DROP = 3'd4;
    localparam logic [KIND_W-1:0] RK_CANCELLED = 3'd5;
    localparam logic [KIND_W-1:0] RK_NOT_FOUND = 3'd6;

    typedef enum logic [2:0] {
        SCAN_BEST,
        SCAN_CANCEL,
        SCAN_BOOK,
        SCAN_DEPTH,
        SCAN_FREE
    } scan_mode_t;

    typedef struct packed {
        logic              side;
        logic [ID_W-1:0]    id;
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
        logic [31:0]        arrival;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    typedef struct packed {
        logic              load;
        logic              scan_start;
        scan_mode_t        scan_mode;
        logic              trade;
        logic              rest;
        logic              cancel_clear;
        logic              set_status;
        logic [KIND_W-1:0] status;
        logic              emit_last;
    } dp_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic found;
        logic price_ok;
        logic rem_zero;
        logic is_cancel;
        logic is_market;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

### design/lobm_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module lobm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

### design/lobm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lobm_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    output lobm_pkg::dp_cmd_t     cmd,
    input  wire lobm_pkg::dp_sts_t sts
);
    import lobm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISP, ST_MATCH, ST_BWAIT, ST_CHECK, ST_TRADE, ST_FWAIT,
        ST_REST, ST_CWAIT, ST_CFIN, ST_BOOK, ST_BOOKW, ST_DEPTH, ST_DEPTHW, ST_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.scan_mode = SCAN_BEST;
        cmd.status    = RK_FILLED;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISP;
                end
            end
            ST_DISP: begin
                if (sts.is_cancel) begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_CANCEL;
                    state_next     = ST_CWAIT;
                end else begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH: begin
                if (sts.rem_zero) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = RK_FILLED;
                    state_next     = ST_BOOK;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_BEST;
                    state_next     = ST_BWAIT;
                end
            end
            ST_BWAIT: begin
                if (sts.scan_done) state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (sts.found && sts.price_ok) begin
                    state_next = ST_TRADE;
                end else if (sts.is_market) begin
                    cmd.set_status = 1'b1;
                    cmd.status     = RK_MKT_DROP;
                    state_next     = ST_BOOK;
                end else begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_mode  = SCAN_FREE;
                    state_next     = ST_FWAIT;
                end
            end
            ST_TRADE: begin
                if (sts.out_free) begin
                    cmd.trade  = 1'b1;
                    state_next = ST_MATCH;
                end
            end
            ST_FWAIT: begin
                if (sts.scan_done) state_next = ST_REST;
            end
            ST_REST: begin
                cmd.set_status = 1'b1;
                if (sts.found) begin
                    cmd.rest   = 1'b1;
                    cmd.status = RK_RESTED;
                end else begin
                    cmd.status = RK_FULL_DROP;
                end
                state_next = ST_BOOK;
            end
            ST_CWAIT: begin
                if (sts.scan_done) state_next = ST_CFIN;
            end
            ST_CFIN: begin
                cmd.set_status = 1'b1;
                if (sts.found) begin
                    cmd.cancel_clear = 1'b1;
                    cmd.status       = RK_CANCELLED;
                end else begin
                    cmd.status = RK_NOT_FOUND;
                end
                state_next = ST_BOOK;
            end
            ST_BOOK: begin
                cmd.scan_start = 1'b1;
                cmd.scan_mode  = SCAN_BOOK;
                state_next     = ST_BOOKW;
            end
            ST_BOOKW: begin
                if (sts.scan_done) state_next = ST_DEPTH;
            end
            ST_DEPTH: begin
                cmd.scan_start = 1'b1;
                cmd.scan_mode  = SCAN_DEPTH;
                state_next     = ST_DEPTHW;
            end
            ST_DEPTHW: begin
                if (sts.scan_done) state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
endmodule
`default_nettype wire

### design/lobm_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lobm_datapath #(
    parameter int ORDER_SLOTS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lobm_pkg::dp_cmd_t             cmd,
    output lobm_pkg::dp_sts_t                  sts,
    input  wire logic                          s_kind,
    input  wire logic [lobm_pkg::ID_W-1:0]     s_order_id,
    input  wire logic                          s_side,
    input  wire logic                          s_order_kind,
    input  wire logic [lobm_pkg::PRICE_W-1:0]  s_limit_price,
    input  wire logic [lobm_pkg::QTY_W-1:0]    s_order_qty,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lobm_pkg::KIND_W-1:0]        m_result_kind,
    output logic [lobm_pkg::ID_W-1:0]          m_buyer_id,
    output logic [lobm_pkg::ID_W-1:0]          m_seller_id,
    output logic [lobm_pkg::PRICE_W-1:0]       m_trade_price,
    output logic [lobm_pkg::QTY_W-1:0]         m_trade_qty,
    output logic                               m_last_result,
    output logic [lobm_pkg::PRICE_W-1:0]       m_best_bid,
    output logic [lobm_pkg::PRICE_W-1:0]       m_best_ask,
    output logic [lobm_pkg::DEPTH_W-1:0]       m_bid_depth,
    output logic [lobm_pkg::DEPTH_W-1:0]       m_ask_depth,
    output logic [lobm_pkg::CNT_W-1:0]         m_resting_count
);
    import lobm_pkg::*;

    localparam int IDX_W = $clog2(ORDER_SLOTS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORDER_SLOTS - 1);

    // latched request
    logic               is_cancel_reg, side_reg, market_reg;
    logic [ID_W-1:0]    id_reg;
    logic [PRICE_W-1:0] lim_reg;
    logic [QTY_W-1:0]   rem_reg;
    logic [KIND_W-1:0]  status_reg;

    // book state
    logic [ORDER_SLOTS-1:0] valid_reg;
    logic [31:0]            arr_cnt_reg;

    // scan sequencer
    logic             issuing_reg, pend_reg;
    logic [IDX_W-1:0] iss_idx_reg, pend_idx_reg;
    scan_mode_t       mode_reg;

    // scan accumulators
    logic               found_reg;
    logic [IDX_W-1:0]   bidx_reg;
    slot_rec_t          brec_reg;
    logic [31:0]        bage_reg;
    logic               bidf_reg, askf_reg;
    logic [PRICE_W-1:0] bidp_reg, askp_reg;
    logic [DEPTH_W-1:0] bsum_reg, asum_reg;
    logic [CNT_W-1:0]   cnt_reg;

    // output register
    logic               m_valid_reg, m_last_reg;
    logic [KIND_W-1:0]  m_kind_reg;
    logic [ID_W-1:0]    m_buyer_reg, m_seller_reg;
    logic [PRICE_W-1:0] m_price_reg, m_bid_reg, m_ask_reg;
    logic [QTY_W-1:0]   m_qty_reg;
    logic [DEPTH_W-1:0] m_bdep_reg, m_adep_reg;
    logic [CNT_W-1:0]   m_cnt_reg;

    logic [REC_W-1:0] ram_rdata, ram_wdata;
    logic             ram_we;
    slot_rec_t        rec, wrec;
    logic             rv, opp, out_free, better;
    logic [31:0]      rec_age;
    logic [QTY_W-1:0] fill_qty, left_qty;

    assign rec      = slot_rec_t'(ram_rdata);
    assign rv       = valid_reg[pend_idx_reg];
    assign opp      = ~side_reg;
    assign rec_age  = arr_cnt_reg - rec.arrival;
    assign out_free = !m_valid_reg || m_ready;
    assign fill_qty = (rem_reg < brec_reg.qty) ? rem_reg : brec_reg.qty;
    assign left_qty = brec_reg.qty - fill_qty;

    always_comb begin
        if (!found_reg) begin
            better = 1'b1;
        end else if (rec.price == brec_reg.price) begin
            better = rec_age > bage_reg;
        end else if (opp == 1'b0) begin
            better = rec.price > brec_reg.price;
        end else begin
            better = rec.price < brec_reg.price;
        end
    end

    always_comb begin
        wrec   = brec_reg;
        ram_we = 1'b0;
        if (cmd.trade) begin
            wrec.qty = left_qty;
            ram_we   = 1'b1;
        end else if (cmd.rest) begin
            wrec.side    = side_reg;
            wrec.id      = id_reg;
            wrec.price   = lim_reg;
            wrec.qty     = rem_reg;
            wrec.arrival = arr_cnt_reg;
            ram_we       = 1'b1;
        end
        ram_wdata = REC_W'(wrec);
    end

    lobm_ram #(
        .WIDTH (REC_W),
        .DEPTH (ORDER_SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (bidx_reg),
        .wdata (ram_wdata),
        .raddr (iss_idx_reg),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            arr_cnt_reg <= '0;
            issuing_reg <= 1'b0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg <= issuing_reg;
            if (cmd.scan_start) begin
                issuing_reg <= 1'b1;
            end else if (issuing_reg && iss_idx_reg == LAST_IDX) begin
                issuing_reg <= 1'b0;
            end
            if (cmd.trade && left_qty == '0) valid_reg[bidx_reg] <= 1'b0;
            if (cmd.cancel_clear)            valid_reg[bidx_reg] <= 1'b0;
            if (cmd.rest) begin
                valid_reg[bidx_reg] <= 1'b1;
                arr_cnt_reg         <= arr_cnt_reg + 32'd1;
            end
            if (cmd.trade || cmd.emit_last) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        pend_idx_reg <= iss_idx_reg;
        if (cmd.scan_start) begin
            iss_idx_reg <= '0;
            mode_reg    <= cmd.scan_mode;
        end else if (issuing_reg && iss_idx_reg != LAST_IDX) begin
            iss_idx_reg <= iss_idx_reg + 1'b1;
        end

        if (cmd.load) begin
            is_cancel_reg <= s_kind;
            side_reg      <= s_side;
            market_reg    <= s_order_kind;
            id_reg        <= s_order_id;
            lim_reg       <= (s_limit_price == '0) ? PRICE_W'(1) : s_limit_price;
            rem_reg       <= s_kind ? '0 : s_order_qty;
        end
        if (cmd.trade)      rem_reg    <= rem_reg - fill_qty;
        if (cmd.set_status) status_reg <= cmd.status;

        if (cmd.scan_start) begin
            found_reg <= 1'b0;
            if (cmd.scan_mode == SCAN_BOOK) begin
                bidf_reg <= 1'b0;
                askf_reg <= 1'b0;
                cnt_reg  <= '0;
            end
            if (cmd.scan_mode == SCAN_DEPTH) begin
                bsum_reg <= '0;
                asum_reg <= '0;
            end
        end else if (pend_reg) begin
            case (mode_reg)
                SCAN_BEST: begin
                    if (rv && rec.side == opp && better) begin
                        found_reg <= 1'b1;
                        bidx_reg  <= pend_idx_reg;
                        brec_reg  <= rec;
                        bage_reg  <= rec_age;
                    end
                end
                SCAN_CANCEL: begin
                    if (rv && rec.id == id_reg && (!found_reg || rec_age > bage_reg)) begin
                        found_reg <= 1'b1;
                        bidx_reg  <= pend_idx_reg;
                        bage_reg  <= rec_age;
                    end
                end
                SCAN_FREE: begin
                    if (!rv && !found_reg) begin
                        found_reg <= 1'b1;
                        bidx_reg  <= pend_idx_reg;
                    end
                end
                SCAN_BOOK: begin
                    if (rv) begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (!rec.side && (!bidf_reg || rec.price > bidp_reg)) begin
                            bidf_reg <= 1'b1;
                            bidp_reg <= rec.price;
                        end
                        if (rec.side && (!askf_reg || rec.price < askp_reg)) begin
                            askf_reg <= 1'b1;
                            askp_reg <= rec.price;
                        end
                    end
                end
                SCAN_DEPTH: begin
                    if (rv && !rec.side && bidf_reg && rec.price == bidp_reg) begin
                        bsum_reg <= bsum_reg + DEPTH_W'(rec.qty);
                    end
                    if (rv && rec.side && askf_reg && rec.price == askp_reg) begin
                        asum_reg <= asum_reg + DEPTH_W'(rec.qty);
                    end
                end
                default: ;
            endcase
        end

        if (cmd.trade) begin
            m_kind_reg   <= RK_TRADE;
            m_buyer_reg  <= side_reg ? brec_reg.id : id_reg;
            m_seller_reg <= side_reg ? id_reg : brec_reg.id;
            m_price_reg  <= brec_reg.price;
            m_qty_reg    <= fill_qty;
            m_last_reg   <= 1'b0;
            m_bid_reg    <= '0;
            m_ask_reg    <= '0;
            m_bdep_reg   <= '0;
            m_adep_reg   <= '0;
            m_cnt_reg    <= '0;
        end else if (cmd.emit_last) begin
            m_kind_reg   <= status_reg;
            m_buyer_reg  <= '0;
            m_seller_reg <= '0;
            m_price_reg  <= '0;
            m_qty_reg    <= '0;
            m_last_reg   <= 1'b1;
            m_bid_reg    <= bidf_reg ? bidp_reg : '0;
            m_ask_reg    <= askf_reg ? askp_reg : '0;
            m_bdep_reg   <= bsum_reg;
            m_adep_reg   <= asum_reg;
            m_cnt_reg    <= cnt_reg;
        end
    end

    always_comb begin
        sts.scan_done = pend_reg && pend_idx_reg == LAST_IDX;
        sts.found     = found_reg;
        sts.price_ok  = market_reg || (side_reg ? lim_reg <= brec_reg.price
                                                : lim_reg >= brec_reg.price);
        sts.rem_zero  = rem_reg == '0;
        sts.is_cancel = is_cancel_reg;
        sts.is_market = market_reg;
        sts.out_free  = out_free;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kind   = m_kind_reg;
    assign m_buyer_id      = m_buyer_reg;
    assign m_seller_id     = m_seller_reg;
    assign m_trade_price   = m_price_reg;
    assign m_trade_qty     = m_qty_reg;
    assign m_last_result   = m_last_reg;
    assign m_best_bid      = m_bid_reg;
    assign m_best_ask      = m_ask_reg;
    assign m_bid_depth     = m_bdep_reg;
    assign m_ask_depth     = m_adep_reg;
    assign m_resting_count = m_cnt_reg;

    a_no_write_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> !issuing_reg && !pend_reg)
        else $error("slot write during a scan");
    a_emit_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.trade || cmd.emit_last) |-> out_free)
        else $error("result register overwritten");
    a_trade_needs_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.trade |-> found_reg && rem_reg != '0)
        else $error("trade without a matching resting order");
    a_last_is_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_last_reg) |-> m_kind_reg != RK_TRADE)
        else $error("trade flagged as last result");
endmodule
`default_nettype wire

### design/limit_order_book_matcher.sv
`timescale 1ns / 1ps
`default_nettype none
// Price-time priority limit order book with up to ORDER_SLOTS resting orders.
// Each request is an add (limit or market) or a cancel by id. An add matches
// the opposite side best price first, earliest arrival first, giving one trade
// result per fill at the resting price; every request ends with one status
// result (last_result set) carrying best bid/ask, depth at each and the number
// of resting orders. Orders live in a slot RAM with a registered read, and
// every decision is a sequential sweep over all slots, one slot per cycle.
// Trade and status results wait while the result side stalls. One request is
// in flight at a time; a new request is taken as soon as the last result of
// the previous one sits in the output register.
module limit_order_book_matcher #(
    parameter int ORDER_SLOTS = 32
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_kind,
    input  wire logic [lobm_pkg::ID_W-1:0]     s_order_id,
    input  wire logic                          s_side,
    input  wire logic                          s_order_kind,
    input  wire logic [lobm_pkg::PRICE_W-1:0]  s_limit_price,
    input  wire logic [lobm_pkg::QTY_W-1:0]    s_order_qty,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [lobm_pkg::KIND_W-1:0]        m_result_kind,
    output logic [lobm_pkg::ID_W-1:0]          m_buyer_id,
    output logic [lobm_pkg::ID_W-1:0]          m_seller_id,
    output logic [lobm_pkg::PRICE_W-1:0]       m_trade_price,
    output logic [lobm_pkg::QTY_W-1:0]         m_trade_qty,
    output logic                               m_last_result,
    output logic [lobm_pkg::PRICE_W-1:0]       m_best_bid,
    output logic [lobm_pkg::PRICE_W-1:0]       m_best_ask,
    output logic [lobm_pkg::DEPTH_W-1:0]       m_bid_depth,
    output logic [lobm_pkg::DEPTH_W-1:0]       m_ask_depth,
    output logic [lobm_pkg::CNT_W-1:0]         m_resting_count
);
    import lobm_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    // sequencing: dispatch, match loop, rest/cancel, snapshot sweeps
    lobm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // slot store, sweep unit and result register
    lobm_datapath #(
        .ORDER_SLOTS (ORDER_SLOTS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_kind          (s_kind),
        .s_order_id      (s_order_id),
        .s_side          (s_side),
        .s_order_kind    (s_order_kind),
        .s_limit_price   (s_limit_price),
        .s_order_qty     (s_order_qty),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_buyer_id      (m_buyer_id),
        .m_seller_id     (m_seller_id),
        .m_trade_price   (m_trade_price),
        .m_trade_qty     (m_trade_qty),
        .m_last_result   (m_last_result),
        .m_best_bid      (m_best_bid),
        .m_best_ask      (m_best_ask),
        .m_bid_depth     (m_bid_depth),
        .m_ask_depth     (m_ask_depth),
        .m_resting_count (m_resting_count)
    );
endmodule
`default_nettype wire
